// ----- rtl/rrss_pkg.sv -----
// Shared types, event codes and constants of the round-robin slot scheduler.
`default_nettype none

package rrss_pkg;

   // Default number of job slots and the widest slot index the command struct carries.
   localparam int SLOTS_DEFAULT = 4;
   localparam int SLOT_IDX_MAX_W = 4;

   // Fixed field widths of the result item.
   localparam int SLOT_FIELD_W = 2;
   localparam int MASK_W = 4;

   // Slice length after reset.
   localparam logic [7:0] SLICE_LENGTH_RESET = 8'd3;

   // Event codes.
   localparam logic [2:0] REQ_START         = 3'd0;
   localparam logic [2:0] REQ_KILL          = 3'd1;
   localparam logic [2:0] REQ_SCHEDULE      = 3'd2;
   localparam logic [2:0] REQ_INTERRUPT     = 3'd3;
   localparam logic [2:0] REQ_LEAVE         = 3'd4;
   localparam logic [2:0] REQ_FOCUS_NEXT    = 3'd5;
   localparam logic [2:0] REQ_FOCUS_CONSOLE = 3'd6;

   // Leave kinds.
   localparam logic LEAVE_YIELD = 1'b0;
   localparam logic LEAVE_EXIT  = 1'b1;

   typedef struct packed {
      logic [2:0] req_type;
      logic [2:0] job_index;
      logic       load_ok;
      logic       timer_tick;
      logic       break_request;
      logic       leave_kind;
   } req_item_type;

   typedef struct packed {
      logic                    accepted;
      logic [SLOT_FIELD_W-1:0] chosen_slot;
      logic                    has_running;
      logic [SLOT_FIELD_W-1:0] running_slot;
      logic                    has_focus;
      logic [SLOT_FIELD_W-1:0] focus_slot;
      logic [MASK_W-1:0]       ended_mask;
      logic [MASK_W-1:0]       killed_mask;
      logic                    any_runnable;
   } rsp_item_type;

   // Update of the slot flag table; end wins over take and kill on the same slot.
   typedef struct packed {
      logic                      take_en;
      logic [SLOT_IDX_MAX_W-1:0] take_idx;
      logic                      kill_en;
      logic [SLOT_IDX_MAX_W-1:0] kill_idx;
      logic                      end_en;
      logic [SLOT_IDX_MAX_W-1:0] end_idx;
   } tbl_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/rrss_slot_table.sv -----
// Per-slot runnable and kill-pending flags with a one-command-per-cycle update port.
`default_nettype none

module rrss_slot_table #(
   parameter int SLOTS = rrss_pkg::SLOTS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire rrss_pkg::tbl_cmd_type cmd,
   output logic [SLOTS-1:0]           runnable,
   output logic [SLOTS-1:0]           kill_pend,
   output logic                       any_runnable
);
   import rrss_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [SLOTS-1:0] runnable_ff, runnable_in;
   logic [SLOTS-1:0] kill_ff, kill_in;

   always_comb begin
      runnable_in = runnable_ff;
      kill_in     = kill_ff;
      for (int i = 0; i < SLOTS; i++) begin
         if (cmd.take_en && cmd.take_idx[IW-1:0] == IW'(i)) begin
            runnable_in[i] = 1'b1;
            kill_in[i]     = 1'b0;
         end
         if (cmd.kill_en && cmd.kill_idx[IW-1:0] == IW'(i)) begin
            kill_in[i] = 1'b1;
         end
         if (cmd.end_en && cmd.end_idx[IW-1:0] == IW'(i)) begin
            runnable_in[i] = 1'b0;
            kill_in[i]     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         runnable_ff <= '0;
         kill_ff     <= '0;
      end else begin
         runnable_ff <= runnable_in;
         kill_ff     <= kill_in;
      end
   end

   assign runnable     = runnable_ff;
   assign kill_pend    = kill_ff;
   assign any_runnable = |runnable_ff;

endmodule

`default_nettype wire

// ----- rtl/round_robin_slot_scheduler.sv -----
// Top level of the round-robin slot scheduler: event sequencer, slot scan and result register.
`default_nettype none

// Round-robin slot scheduler. Keeps SLOTS job slots (runnable and kill-pending
// flags), a focused slot or console focus, a running slot, a round-robin
// pointer and a slice countdown, and answers every event item on req_ with
// exactly one status item on rsp_. An item is taken only while req_stall is
// low, which is whenever the sequencer is idle; it then runs in an execute
// phase and a finish phase that loads the result register. Kill, interrupt,
// leave, focus-console and unused codes need no scan and go straight from
// execute to finish. Start and focus-next examine one slot per cycle and
// stop at the first hit. Schedule always visits all SLOTS slots once,
// starting at the round-robin pointer, retiring kill-pending slots and
// dispatching the first clean runnable one on the way. A result waiting in
// the output register does not block the next item; only the finish phase
// waits for it to be taken. The slice length is written through csr_
// (always ready); the user must write it only while the block is idle, which
// the block itself does not enforce. It resets to 3.
module round_robin_slot_scheduler #(
   parameter int SLOTS = rrss_pkg::SLOTS_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   // event items
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire rrss_pkg::req_item_type req_data,
   // status items
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output rrss_pkg::rsp_item_type      rsp_data,
   // slice length register
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [7:0]                  csr_data
);
   import rrss_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]    state_ff, state_in;
   req_item_type  item_ff, item_in;
   logic [IW-1:0] idx_ff, idx_in;         // slot under examination
   logic [IW-1:0] cnt_ff, cnt_in;         // slots visited by schedule
   logic          scan_none_ff, scan_none_in;
   logic          acc_ff, acc_in;
   logic [IW-1:0] chosen_ff, chosen_in;
   logic [MASK_W-1:0] ended_ff, ended_in;
   logic [MASK_W-1:0] killed_ff, killed_in;
   logic          focus_valid_ff, focus_valid_in;
   logic [IW-1:0] focus_ff, focus_in;
   logic          run_valid_ff, run_valid_in;
   logic [IW-1:0] run_ff, run_in;
   logic [IW-1:0] rr_ff, rr_in;
   logic [7:0]    slice_left_ff, slice_left_in;
   logic [7:0]    slice_len_ff, slice_len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_data_ff, rsp_data_in;

   tbl_cmd_type      cmd;
   logic [SLOTS-1:0] runnable;
   logic [SLOTS-1:0] kill_pend;
   logic             any_runnable;

   // Interrupt, kill and scan helpers.
   logic [7:0]    slice_dec;
   logic          kill_run;
   logic [IW-1:0] job_idx;
   logic [IW-1:0] idx_next;

   rrss_slot_table #(
      .SLOTS(SLOTS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .runnable    (runnable),
      .kill_pend   (kill_pend),
      .any_runnable(any_runnable)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign idx_next  = (idx_ff == LAST) ? '0 : IW'(idx_ff + 1'b1);
   assign job_idx   = IW'(item_ff.job_index);
   assign slice_dec = (item_ff.timer_tick && slice_left_ff != 8'd0)
                      ? slice_left_ff - 8'd1 : slice_left_ff;
   assign kill_run  = kill_pend[run_ff]
                      || (item_ff.break_request && focus_valid_ff && focus_ff == run_ff);

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      scan_none_in   = scan_none_ff;
      acc_in         = acc_ff;
      chosen_in      = chosen_ff;
      ended_in       = ended_ff;
      killed_in      = killed_ff;
      focus_valid_in = focus_valid_ff;
      focus_in       = focus_ff;
      run_valid_in   = run_valid_ff;
      run_in         = run_ff;
      rr_in          = rr_ff;
      slice_left_in  = slice_left_ff;
      slice_len_in   = slice_len_ff;
      rsp_data_in    = rsp_data_ff;
      cmd            = '0;

      // Drop the result once it is taken.
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         slice_len_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in   = req_data;
               acc_in    = 1'b0;
               chosen_in = '0;
               ended_in  = '0;
               killed_in = '0;
               cnt_in    = '0;
               scan_none_in = 1'b0;
               idx_in    = '0;
               if (req_data.req_type == REQ_SCHEDULE) begin
                  // Set the running slot aside; the scan starts at the pointer.
                  run_valid_in = 1'b0;
                  idx_in       = rr_ff;
               end else if (req_data.req_type == REQ_FOCUS_NEXT && focus_valid_ff) begin
                  idx_in       = (focus_ff == LAST) ? '0 : IW'(focus_ff + 1'b1);
                  scan_none_in = (focus_ff == LAST);
               end
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            unique case (item_ff.req_type)
               REQ_START: begin
                  if (!item_ff.load_ok) begin
                     state_in = ST_FIN;
                  end else if (!runnable[idx_ff]) begin
                     cmd.take_en    = 1'b1;
                     cmd.take_idx   = SLOT_IDX_MAX_W'(idx_ff);
                     focus_valid_in = 1'b1;
                     focus_in       = idx_ff;
                     acc_in         = 1'b1;
                     chosen_in      = idx_ff;
                     state_in       = ST_FIN;
                  end else if (idx_ff == LAST) begin
                     state_in = ST_FIN;
                  end else begin
                     idx_in = idx_next;
                  end
               end

               REQ_KILL: begin
                  if (int'(item_ff.job_index) < SLOTS && runnable[job_idx]) begin
                     cmd.kill_en  = 1'b1;
                     cmd.kill_idx = SLOT_IDX_MAX_W'(job_idx);
                     acc_in       = 1'b1;
                  end
                  state_in = ST_FIN;
               end

               REQ_SCHEDULE: begin
                  if (runnable[idx_ff] && kill_pend[idx_ff]) begin
                     // Retire a killed slot.
                     cmd.end_en  = 1'b1;
                     cmd.end_idx = SLOT_IDX_MAX_W'(idx_ff);
                     ended_in    = ended_ff | (MASK_W'(1) << idx_ff);
                     killed_in   = killed_ff | (MASK_W'(1) << idx_ff);
                     if (focus_valid_ff && focus_ff == idx_ff) begin
                        focus_valid_in = 1'b0;
                     end
                  end else if (runnable[idx_ff] && !acc_ff) begin
                     // Dispatch the first clean runnable slot at or after the pointer.
                     run_valid_in  = 1'b1;
                     run_in        = idx_ff;
                     rr_in         = idx_next;
                     slice_left_in = slice_len_ff;
                     acc_in        = 1'b1;
                     chosen_in     = idx_ff;
                  end
                  idx_in = idx_next;
                  if (cnt_ff == LAST) begin
                     state_in = ST_FIN;
                  end else begin
                     cnt_in = IW'(cnt_ff + 1'b1);
                  end
               end

               REQ_INTERRUPT: begin
                  slice_left_in = slice_dec;
                  if (item_ff.break_request && focus_valid_ff) begin
                     cmd.kill_en  = 1'b1;
                     cmd.kill_idx = SLOT_IDX_MAX_W'(focus_ff);
                  end
                  if (run_valid_ff) begin
                     if (kill_run) begin
                        cmd.end_en   = 1'b1;
                        cmd.end_idx  = SLOT_IDX_MAX_W'(run_ff);
                        ended_in     = MASK_W'(1) << run_ff;
                        killed_in    = MASK_W'(1) << run_ff;
                        run_valid_in = 1'b0;
                        if (focus_valid_ff && focus_ff == run_ff) begin
                           focus_valid_in = 1'b0;
                        end
                     end else if (slice_dec == 8'd0) begin
                        // Preempt: slice used up, slot stays runnable.
                        run_valid_in = 1'b0;
                     end
                  end
                  state_in = ST_FIN;
               end

               REQ_LEAVE: begin
                  if (run_valid_ff) begin
                     run_valid_in = 1'b0;
                     if (item_ff.leave_kind == LEAVE_EXIT) begin
                        cmd.end_en  = 1'b1;
                        cmd.end_idx = SLOT_IDX_MAX_W'(run_ff);
                        ended_in    = MASK_W'(1) << run_ff;
                        if (focus_valid_ff && focus_ff == run_ff) begin
                           focus_valid_in = 1'b0;
                        end
                     end
                  end
                  state_in = ST_FIN;
               end

               REQ_FOCUS_NEXT: begin
                  if (scan_none_ff) begin
                     focus_valid_in = 1'b0;
                     state_in       = ST_FIN;
                  end else if (runnable[idx_ff]) begin
                     focus_valid_in = 1'b1;
                     focus_in       = idx_ff;
                     state_in       = ST_FIN;
                  end else if (idx_ff == LAST) begin
                     focus_valid_in = 1'b0;
                     state_in       = ST_FIN;
                  end else begin
                     idx_in = idx_next;
                  end
               end

               REQ_FOCUS_CONSOLE: begin
                  focus_valid_in = 1'b0;
                  state_in       = ST_FIN;
               end

               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end

         ST_FIN: begin
            // Load the result once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.accepted     = acc_ff;
               rsp_data_in.chosen_slot  = acc_ff ? SLOT_FIELD_W'(chosen_ff) : '0;
               rsp_data_in.has_running  = run_valid_ff;
               rsp_data_in.running_slot = run_valid_ff ? SLOT_FIELD_W'(run_ff) : '0;
               rsp_data_in.has_focus    = focus_valid_ff;
               rsp_data_in.focus_slot   = focus_valid_ff ? SLOT_FIELD_W'(focus_ff) : '0;
               rsp_data_in.ended_mask   = ended_ff;
               rsp_data_in.killed_mask  = killed_ff;
               rsp_data_in.any_runnable = any_runnable;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         focus_valid_ff <= 1'b0;
         focus_ff       <= '0;
         run_valid_ff   <= 1'b0;
         run_ff         <= '0;
         rr_ff          <= '0;
         slice_left_ff  <= 8'd0;
         slice_len_ff   <= SLICE_LENGTH_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         focus_valid_ff <= focus_valid_in;
         focus_ff       <= focus_in;
         run_valid_ff   <= run_valid_in;
         run_ff         <= run_in;
         rr_ff          <= rr_in;
         slice_left_ff  <= slice_left_in;
         slice_len_ff   <= slice_len_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      scan_none_ff <= scan_none_in;
      acc_ff       <= acc_in;
      chosen_ff    <= chosen_in;
      ended_ff     <= ended_in;
      killed_ff    <= killed_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ----- rtl/rrss_checker.sv -----
// Port-level checks of the round-robin slot scheduler and their bind to the top level.
`default_nettype none

module rrss_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_stall,
   input wire                         rsp_valid,
   input wire                         rsp_stall,
   input wire rrss_pkg::rsp_item_type rsp_data
);
   import rrss_pkg::*;

   // Reset leaves the block idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   // An accepted item holds off the next one: the block stalls in the cycle after an accept.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken right after an accept");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // A killed slot is always also an ended slot.
   a_killed_in_ended: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.killed_mask & ~rsp_data.ended_mask) == '0))
      else $error("killed slot not reported as ended");

endmodule

bind round_robin_slot_scheduler rrss_checker u_rrss_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

`default_nettype wire
